// ===== src/calendar_day_offset_macros.svh =====
// ----------------------------------------------------------------------------
// calendar_day_offset_macros
// assertion macros for the checker file
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DAY_OFFSET_MACROS_SVH
`define CALENDAR_DAY_OFFSET_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define CDO_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define CDO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/cdo_pkg.sv =====
// ----------------------------------------------------------------------------
// cdo_pkg
// types, constants, tables and microcode for the calendar day offset block
// ----------------------------------------------------------------------------
package cdo_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int DOY_W   = 9;
    localparam int YREM_W  = 9;

    localparam logic [YEAR_W-1:0]  YEAR_MIN   = YEAR_W'(1900);
    localparam logic [YEAR_W-1:0]  YEAR_MAX   = YEAR_W'(9999);
    localparam logic [YEAR_W-1:0]  YEAR_CYCLE = YEAR_W'(400);
    localparam logic [YREM_W-1:0]  YREM_LAST  = YREM_W'(399);
    localparam logic [MONTH_W-1:0] MONTH_JAN  = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB  = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_DEC  = MONTH_W'(12);
    localparam logic [DAY_W-1:0]   DAY_FIRST  = DAY_W'(1);
    localparam logic [DAY_W-1:0]   DAY_DEC_LAST = DAY_W'(31);

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_CLAMP,
        OP_MODSUB,
        OP_DCLAMP,
        OP_WALK,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_IN_BEAT,
        C_REM_GE,
        C_WALK_MORE,
        C_OUT_BUSY
    } t_cond;

    typedef enum logic [2:0] {
        S_LOAD,
        S_CLAMP,
        S_MOD,
        S_DCLAMP,
        S_WALK,
        S_EMIT
    } t_step;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step tgt_t;
        t_step tgt_f;
    } t_uword;

    // control store: op, jump condition, target when true, target when false
    function automatic t_uword cdo_microcode(input t_step step);
        t_uword uw;
        case (step)
            S_LOAD:   uw = '{OP_LOAD,   C_IN_BEAT,   S_CLAMP,  S_LOAD};
            S_CLAMP:  uw = '{OP_CLAMP,  C_ALWAYS,    S_MOD,    S_MOD};
            S_MOD:    uw = '{OP_MODSUB, C_REM_GE,    S_MOD,    S_DCLAMP};
            S_DCLAMP: uw = '{OP_DCLAMP, C_ALWAYS,    S_WALK,   S_WALK};
            S_WALK:   uw = '{OP_WALK,   C_WALK_MORE, S_WALK,   S_EMIT};
            S_EMIT:   uw = '{OP_EMIT,   C_OUT_BUSY,  S_EMIT,   S_LOAD};
            default:  uw = '{OP_LOAD,   C_ALWAYS,    S_LOAD,   S_LOAD};
        endcase
        return uw;
    endfunction

    // leap from the year modulo 400
    function automatic logic is_leap(input logic [YREM_W-1:0] r);
        return (r[1:0] == 2'b00) &&
               !(r == YREM_W'(100) || r == YREM_W'(200) || r == YREM_W'(300));
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
        logic [DAY_W-1:0] n;
        case (m)
            4'd2:                      n = leap ? DAY_W'(29) : DAY_W'(28);
            4'd4, 4'd6, 4'd9, 4'd11:   n = DAY_W'(30);
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, 4'd12:        n = DAY_W'(31);
            default:                   n = DAY_W'(0);
        endcase
        return n;
    endfunction

    function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] n;
        case (m)
            4'd2:    n = DOY_W'(31);
            4'd3:    n = DOY_W'(59);
            4'd4:    n = DOY_W'(90);
            4'd5:    n = DOY_W'(120);
            4'd6:    n = DOY_W'(151);
            4'd7:    n = DOY_W'(181);
            4'd8:    n = DOY_W'(212);
            4'd9:    n = DOY_W'(243);
            4'd10:   n = DOY_W'(273);
            4'd11:   n = DOY_W'(304);
            4'd12:   n = DOY_W'(334);
            default: n = DOY_W'(0);
        endcase
        return n;
    endfunction

endpackage

// ===== src/cdo_if.sv =====
// ----------------------------------------------------------------------------
// cdo_in_if / cdo_out_if
// valid/ready channels carrying request and result beats
// ----------------------------------------------------------------------------
interface cdo_in_if
    import cdo_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) ();
    logic                   valid;
    logic                   ready;
    logic                   func;
    logic [DAY_W-1:0]       start_day;
    logic [MONTH_W-1:0]     start_month;
    logic [YEAR_W-1:0]      start_year;
    logic [COUNT_WIDTH-1:0] day_count;

    modport source (output valid, func, start_day, start_month, start_year, day_count,
                    input ready);
    modport sink   (input valid, func, start_day, start_month, start_year, day_count,
                    output ready);
endinterface

interface cdo_out_if
    import cdo_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [DAY_W-1:0]   new_day;
    logic [MONTH_W-1:0] new_month;
    logic [YEAR_W-1:0]  new_year;
    logic [DOY_W-1:0]   day_of_year;
    logic               range_error;

    modport source (output valid, new_day, new_month, new_year, day_of_year, range_error,
                    input ready);
    modport sink   (input valid, new_day, new_month, new_year, day_of_year, range_error,
                    output ready);
endinterface

// ===== src/calendar_day_offset.sv =====
// ----------------------------------------------------------------------------
// calendar_day_offset
// moves a date forward or backward by a day count, one month per step,
// under a small microcoded sequencer
// ----------------------------------------------------------------------------
// channel  dir  port   beat
// request  in   i_in   func, start_day, start_month, start_year, day_count
// result   out  o_out  new_day, new_month, new_year, day_of_year, range_error
//
// a beat steps through load, field clamp, repeated subtraction of 400 from the
// year, day clamp, the month walk and emit
// reset clears the step counter and the result valid
// a stalled result sits in the output register while the next beat is taken
// ----------------------------------------------------------------------------
module calendar_day_offset
    import cdo_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cdo_in_if.sink     i_in,
    cdo_out_if.source  o_out
);

    t_step                  r_step;
    t_step                  n_step;
    t_uword                 uw;
    logic                   cond;

    logic                   r_sub;
    logic                   r_err;
    logic [DAY_W-1:0]       r_day;
    logic [MONTH_W-1:0]     r_month;
    logic [YEAR_W-1:0]      r_year;
    logic [YEAR_W-1:0]      r_yrem;
    logic [COUNT_WIDTH-1:0] r_cnt;

    logic                   r_o_valid;
    logic [DAY_W-1:0]       r_o_day;
    logic [MONTH_W-1:0]     r_o_month;
    logic [YEAR_W-1:0]      r_o_year;
    logic [DOY_W-1:0]       r_o_doy;
    logic                   r_o_err;

    logic                   leap;
    logic [DAY_W-1:0]       dim;
    logic [DAY_W-1:0]       dim_prev;
    logic [DAY_W-1:0]       rem;
    logic [MONTH_W-1:0]     m_clamp;
    logic [YEAR_W-1:0]      y_clamp;
    logic [DOY_W-1:0]       doy;
    logic                   out_busy;

    assign uw       = cdo_microcode(r_step);
    assign out_busy = r_o_valid && !o_out.ready;
    assign leap     = is_leap(r_yrem[YREM_W-1:0]);
    assign dim      = month_days(r_month, leap);
    assign dim_prev = month_days(r_month - MONTH_W'(1), leap);
    assign rem      = dim - r_day;
    assign doy      = days_before(r_month) + DOY_W'(r_day)
                      + DOY_W'(leap && (r_month > MONTH_FEB));

    always_comb begin
        m_clamp = r_month;
        if (r_month == MONTH_W'(0)) begin
            m_clamp = MONTH_JAN;
        end else if (r_month > MONTH_DEC) begin
            m_clamp = MONTH_DEC;
        end
        y_clamp = r_year;
        if (r_year < YEAR_MIN) begin
            y_clamp = YEAR_MIN;
        end else if (r_year > YEAR_MAX) begin
            y_clamp = YEAR_MAX;
        end
    end

    always_comb begin
        case (uw.cond)
            C_ALWAYS:    cond = 1'b1;
            C_IN_BEAT:   cond = i_in.valid;
            C_REM_GE:    cond = (r_yrem >= YEAR_CYCLE);
            C_WALK_MORE: cond = (r_cnt != '0) && !r_err;
            C_OUT_BUSY:  cond = out_busy;
            default:     cond = 1'b0;
        endcase
        n_step = cond ? uw.tgt_t : uw.tgt_f;
    end

    assign i_in.ready        = (uw.op == OP_LOAD);
    assign o_out.valid       = r_o_valid;
    assign o_out.new_day     = r_o_day;
    assign o_out.new_month   = r_o_month;
    assign o_out.new_year    = r_o_year;
    assign o_out.day_of_year = r_o_doy;
    assign o_out.range_error = r_o_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= S_LOAD;
            r_o_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (r_o_valid && o_out.ready && (uw.op != OP_EMIT)) begin
                r_o_valid <= 1'b0;
            end
            case (uw.op)
                OP_LOAD: begin
                    r_sub   <= i_in.func;
                    r_day   <= i_in.start_day;
                    r_month <= i_in.start_month;
                    r_year  <= i_in.start_year;
                    r_cnt   <= i_in.day_count;
                    r_err   <= 1'b0;
                end
                OP_CLAMP: begin
                    r_month <= m_clamp;
                    r_year  <= y_clamp;
                    r_yrem  <= y_clamp;
                end
                OP_MODSUB: begin
                    if (r_yrem >= YEAR_CYCLE) begin
                        r_yrem <= r_yrem - YEAR_CYCLE;
                    end
                end
                OP_DCLAMP: begin
                    if (r_day == DAY_W'(0)) begin
                        r_day <= DAY_FIRST;
                    end else if (r_day > dim) begin
                        r_day <= dim;
                    end
                end
                OP_WALK: begin
                    if ((r_cnt != '0) && !r_err) begin
                        if (!r_sub) begin
                            if (COUNT_WIDTH'(rem) >= r_cnt) begin
                                r_day <= r_day + r_cnt[DAY_W-1:0];
                                r_cnt <= '0;
                            end else begin
                                r_cnt <= r_cnt - COUNT_WIDTH'(rem) - COUNT_WIDTH'(1);
                                r_day <= DAY_FIRST;
                                if (r_month == MONTH_DEC) begin
                                    if (r_year == YEAR_MAX) begin
                                        r_day <= DAY_DEC_LAST;
                                        r_err <= 1'b1;
                                    end else begin
                                        r_month <= MONTH_JAN;
                                        r_year  <= r_year + YEAR_W'(1);
                                        r_yrem  <= (r_yrem[YREM_W-1:0] == YREM_LAST) ? '0
                                                   : r_yrem + YEAR_W'(1);
                                    end
                                end else begin
                                    r_month <= r_month + MONTH_W'(1);
                                end
                            end
                        end else begin
                            if (COUNT_WIDTH'(r_day) > r_cnt) begin
                                r_day <= r_day - r_cnt[DAY_W-1:0];
                                r_cnt <= '0;
                            end else begin
                                r_cnt <= r_cnt - COUNT_WIDTH'(r_day);
                                if (r_month == MONTH_JAN) begin
                                    if (r_year == YEAR_MIN) begin
                                        r_day <= DAY_FIRST;
                                        r_err <= 1'b1;
                                    end else begin
                                        r_month <= MONTH_DEC;
                                        r_day   <= DAY_DEC_LAST;
                                        r_year  <= r_year - YEAR_W'(1);
                                        r_yrem  <= (r_yrem == '0) ? YEAR_W'(YREM_LAST)
                                                   : r_yrem - YEAR_W'(1);
                                    end
                                end else begin
                                    r_month <= r_month - MONTH_W'(1);
                                    r_day   <= dim_prev;
                                end
                            end
                        end
                    end
                end
                OP_EMIT: begin
                    if (!out_busy) begin
                        r_o_valid <= 1'b1;
                        r_o_day   <= r_day;
                        r_o_month <= r_month;
                        r_o_year  <= r_year;
                        r_o_doy   <= doy;
                        r_o_err   <= r_err;
                    end
                end
                default: begin
                    r_err <= r_err;
                end
            endcase
        end
    end

endmodule

// ===== src/cdo_checker.sv =====
// ----------------------------------------------------------------------------
// cdo_checker
// port-level checks on the calendar day offset block, bound into calendar_day_offset
// ----------------------------------------------------------------------------
`include "calendar_day_offset_macros.svh"

module cdo_checker
    import cdo_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [DAY_W-1:0]   i_new_day,
    input logic [MONTH_W-1:0] i_new_month,
    input logic [YEAR_W-1:0]  i_new_year,
    input logic [DOY_W-1:0]   i_day_of_year,
    input logic               i_range_error
);

    `CDO_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_new_day) && $stable(i_new_month) && $stable(i_new_year),
        "result beat changed while stalled")

    `CDO_ASSERT_NEXT(a_one_at_a_time, i_in_valid && i_in_ready, !i_in_ready,
        "request taken while a beat is in work")

    `CDO_ASSERT_NOW(a_err_date, i_out_valid && i_range_error,
        (i_new_year == YEAR_MAX && i_new_month == MONTH_DEC && i_new_day == DAY_DEC_LAST) ||
        (i_new_year == YEAR_MIN && i_new_month == MONTH_JAN && i_new_day == DAY_FIRST),
        "range error with a date off the range ends")

    `CDO_ASSERT_NOW(a_jan_doy, i_out_valid && i_new_month == MONTH_JAN,
        i_day_of_year == DOY_W'(i_new_day),
        "january day of year differs from day")

endmodule

bind calendar_day_offset cdo_checker u_cdo_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_new_day     (o_out.new_day),
    .i_new_month   (o_out.new_month),
    .i_new_year    (o_out.new_year),
    .i_day_of_year (o_out.day_of_year),
    .i_range_error (o_out.range_error)
);

// ===== tb/calendar_day_offset_test.sv =====
// ----------------------------------------------------------------------------
// calendar_day_offset_test
// Self-checking bench for the date offset block. Directed dates cover clamped
// fields, leap years, month and year ends and the range limits. Random
// requests follow, driven in bursts against a result side that stalls on
// rotating patterns and twice holds off long enough to back up the input. A
// scoreboard predicts each result and checks the beats in order.
// ----------------------------------------------------------------------------
module calendar_day_offset_test;
    import cdo_pkg::*;

    localparam int COUNT_WIDTH  = 16;
    localparam int RANDOM_ITEMS = 250;
    localparam int HOLD_CYCLES  = 3000;
    localparam int IDLE_LIMIT   = 20000;

    typedef struct packed {
        logic                   sub;
        logic [DAY_W-1:0]       day;
        logic [MONTH_W-1:0]     month;
        logic [YEAR_W-1:0]      year;
        logic [COUNT_WIDTH-1:0] days;
    } t_req;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [DOY_W-1:0]   doy;
        logic               range_error;
    } t_date;

    class date_shift_board;
        t_date expected_dates[$];
        int    errors = 0;
        int    results_seen = 0;

        static function bit leap_year(int unsigned y);
            return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
        endfunction

        static function int unsigned month_length(int unsigned m, int unsigned y);
            case (m)
                2:            return leap_year(y) ? 29 : 28;
                4, 6, 9, 11:  return 30;
                default:      return 31;
            endcase
        endfunction

        function t_date shift_date(t_req r);
            int unsigned d, m, y, n, spare, k, doy;
            bit          err;
            t_date       res;
            d   = r.day;
            m   = r.month;
            y   = r.year;
            n   = r.days;
            err = 1'b0;
            if (m < MONTH_JAN) m = MONTH_JAN;
            if (m > MONTH_DEC) m = MONTH_DEC;
            if (y < YEAR_MIN) y = YEAR_MIN;
            if (y > YEAR_MAX) y = YEAR_MAX;
            if (d < 1) d = 1;
            if (d > month_length(m, y)) d = month_length(m, y);
            if (!r.sub) begin
                while (n != 0) begin
                    spare = month_length(m, y) - d;
                    if (spare >= n) begin
                        d += n;
                        n = 0;
                    end else begin
                        n -= spare + 1;
                        d = 1;
                        m++;
                        if (m > MONTH_DEC) begin
                            m = MONTH_JAN;
                            if (y == YEAR_MAX) begin
                                d   = 31;
                                m   = MONTH_DEC;
                                err = 1'b1;
                                break;
                            end
                            y++;
                        end
                    end
                end
            end else begin
                while (n != 0) begin
                    if (d > n) begin
                        d -= n;
                        n = 0;
                    end else begin
                        n -= d;
                        m--;
                        if (m == 0) begin
                            m = MONTH_DEC;
                            if (y == YEAR_MIN) begin
                                d   = 1;
                                m   = MONTH_JAN;
                                err = 1'b1;
                                break;
                            end
                            y--;
                        end
                        d = month_length(m, y);
                    end
                end
            end
            doy = d;
            for (k = 1; k < m; k++) doy += month_length(k, y);
            res.day         = DAY_W'(d);
            res.month       = MONTH_W'(m);
            res.year        = YEAR_W'(y);
            res.doy         = DOY_W'(doy);
            res.range_error = err;
            return res;
        endfunction

        function void note_request(t_req r);
            expected_dates.push_back(shift_date(r));
        endfunction

        task report_mismatch(string field, int unsigned got, int unsigned want);
            $display("result %0d: %s got %0d, want %0d", results_seen, field, got, want);
            errors++;
        endtask

        task check_result(t_date got);
            t_date want;
            results_seen++;
            if (expected_dates.size() == 0) begin
                report_mismatch("unexpected beat, new_year", got.year, 0);
                return;
            end
            want = expected_dates.pop_front();
            if (got.day != want.day)
                report_mismatch("new_day", got.day, want.day);
            if (got.month != want.month)
                report_mismatch("new_month", got.month, want.month);
            if (got.year != want.year)
                report_mismatch("new_year", got.year, want.year);
            if (got.doy != want.doy)
                report_mismatch("day_of_year", got.doy, want.doy);
            if (got.range_error != want.range_error)
                report_mismatch("range_error", got.range_error, want.range_error);
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   hold_off_due = 1'b0;
    int   burst_left = 0;

    date_shift_board board = new();

    cdo_in_if #(.COUNT_WIDTH(COUNT_WIDTH)) req_ch ();
    cdo_out_if res_ch ();

    calendar_day_offset #(.COUNT_WIDTH(COUNT_WIDTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_req make_req(bit sub, int unsigned d, int unsigned m,
                                      int unsigned y, int unsigned n);
        t_req r;
        r.sub   = sub;
        r.day   = DAY_W'(d);
        r.month = MONTH_W'(m);
        r.year  = YEAR_W'(y);
        r.days  = COUNT_WIDTH'(n);
        return r;
    endfunction

    function automatic int unsigned rand_day_count();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return $urandom_range(0, 400);
        if (pick < 85) return $urandom_range(0, 5000);
        return $urandom_range(0, (1 << COUNT_WIDTH) - 1);
    endfunction

    function automatic t_req rand_date_req(int unsigned y_lo, int unsigned y_hi);
        int unsigned y, m;
        y = $urandom_range(y_lo, y_hi);
        m = $urandom_range(1, 12);
        return make_req($urandom_range(0, 1), $urandom_range(1,
                        date_shift_board::month_length(m, y)), m, y, rand_day_count());
    endfunction

    task automatic send_request(input t_req r);
        bit hit;
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        req_ch.valid       <= 1'b1;
        req_ch.func        <= r.sub;
        req_ch.start_day   <= r.day;
        req_ch.start_month <= r.month;
        req_ch.start_year  <= r.year;
        req_ch.day_count   <= r.days;
        do begin
            @(negedge i_clk);
            hit = req_ch.ready;
            @(posedge i_clk);
        end while (!hit);
    endtask

    always @(posedge i_clk) begin : beat_monitor
        t_req  r;
        t_date q;
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            r = make_req(req_ch.func, req_ch.start_day, req_ch.start_month,
                         req_ch.start_year, req_ch.day_count);
            board.note_request(r);
        end
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            q.day         = res_ch.new_day;
            q.month       = res_ch.new_month;
            q.year        = res_ch.new_year;
            q.doy         = res_ch.day_of_year;
            q.range_error = res_ch.range_error;
            board.check_result(q);
        end
    end

    initial begin : result_sink
        int unsigned span, mask, cyc;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off_due) begin
                hold_off_due = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            span = $urandom_range(20, 200);
            mask = ($urandom_range(0, 3) == 0) ? 8'hff : $urandom_range(1, 255);
            for (cyc = 0; cyc < span; cyc++) begin
                res_ch.ready <= mask[cyc % 8];
                @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("calendar_day_offset_test: done, errors");
        $finish;
    end

    initial begin : stimulus
        t_req        directed[$];
        t_req        r;
        int          k;
        int unsigned pick;
        i_rst_n            <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.func        <= 1'b0;
        req_ch.start_day   <= '0;
        req_ch.start_month <= '0;
        req_ch.start_year  <= '0;
        req_ch.day_count   <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed = '{
            make_req(0, 1, 1, 1900, 0),
            make_req(0, 31, 12, 9999, 0),
            make_req(0, 0, 0, 0, 0),
            make_req(1, 31, 15, 16383, 0),
            make_req(0, 31, 2, 2000, 0),
            make_req(0, 30, 2, 1900, 0),
            make_req(0, 31, 4, 2023, 0),
            make_req(0, 28, 2, 2000, 1),
            make_req(0, 28, 2, 1900, 1),
            make_req(0, 28, 2, 2100, 1),
            make_req(0, 1, 1, 2023, 30),
            make_req(0, 1, 3, 2024, 0),
            make_req(1, 1, 1, 2001, 1),
            make_req(0, 31, 12, 9999, 1),
            make_req(1, 1, 1, 1900, 1),
            make_req(0, 1, 12, 9999, 65535),
            make_req(1, 10, 1, 1900, 65535),
            make_req(0, 15, 6, 4000, 65535),
            make_req(1, 15, 6, 4000, 65535),
            make_req(0, 31, 12, 9998, 1),
            make_req(1, 1, 1, 1901, 1),
            make_req(1, 1, 3, 2000, 1),
            make_req(0, 31, 1, 2023, 31),
            make_req(1, 31, 12, 9999, 32767)
        };
        foreach (directed[idx]) send_request(directed[idx]);

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == 40 || k == 170) hold_off_due = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                r = rand_date_req(YEAR_MIN, YEAR_MAX);
            end else if (pick < 72) begin
                r = rand_date_req(9990, YEAR_MAX);
                r.sub  = 1'b0;
                r.days = COUNT_WIDTH'($urandom_range(0, (1 << COUNT_WIDTH) - 1));
            end else if (pick < 79) begin
                r = rand_date_req(YEAR_MIN, 1910);
                r.sub  = 1'b1;
                r.days = COUNT_WIDTH'($urandom_range(0, (1 << COUNT_WIDTH) - 1));
            end else begin
                r = make_req($urandom_range(0, 1), $urandom_range(0, 31),
                             $urandom_range(0, 15), $urandom_range(0, (1 << YEAR_W) - 1),
                             rand_day_count());
            end
            send_request(r);
        end
        req_ch.valid <= 1'b0;
        @(posedge i_clk);

        while (board.expected_dates.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (board.errors == 0)
            $display("calendar_day_offset_test: done, clean");
        else
            $display("calendar_day_offset_test: done, errors");
        $finish;
    end

endmodule
